// ----- hw/rtl/aesbm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesbm_pkg
// Shared types, codes and AES byte functions for the block mode engine.
// ----------------------------------------------------------------------------
package aesbm_pkg;

    localparam int NumRounds = 10;
    localparam int RkIdxW    = 4;

    typedef enum logic [1:0] {
        MODE_CBC_ENC = 2'd0,
        MODE_CBC_DEC = 2'd1,
        MODE_CTR     = 2'd2,
        MODE_CTR_ALT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3,
        REG_MODE     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        last_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  valid_bytes;
        logic        last_result;
    } out_word_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic start;      // capture input word, open message if needed
        logic key_step;   // compute next round key
        logic round;      // apply whitening or one cipher round
        logic pad_load;   // load the pad block for the extra CBC encrypt result
        logic emit;       // finish and load output register
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic keys_ready;
        logic rounds_done;
        logic need_pad;
    } dp_sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the state, i = 0 is the most significant.
    function automatic logic [7:0] sb(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last_rnd);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[sb(s, 4*((c + r) % 4) + r)];
            end
        end
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = sb(t, 4*c); a1 = sb(t, 4*c + 1);
                a2 = sb(t, 4*c + 2); a3 = sb(t, 4*c + 3);
                al = a0 ^ a1 ^ a2 ^ a3;
                t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] x);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x;
    endfunction
    function automatic logic [7:0] mul11(input logic [7:0] x);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x2 ^ x;
    endfunction
    function automatic logic [7:0] mul13(input logic [7:0] x);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x4 ^ x;
    endfunction
    function automatic logic [7:0] mul14(input logic [7:0] x);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x4 ^ x2;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*((c + r) % 4) + r) -: 8] = inv_sbox(sb(s, 4*c + r));
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = sb(s, 4*c + r);
            end
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = mul14(a[r]) ^ mul11(a[(r + 1) % 4])
                                          ^ mul13(a[(r + 2) % 4]) ^ mul9(a[(r + 3) % 4]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aesbm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesbm_ctrl
// Sequencer: key expansion on message open, ten rounds, output handoff.
// ----------------------------------------------------------------------------
module aesbm_ctrl import aesbm_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    out_busy,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_KEYS  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_KEYS;
                end
            end
            ST_KEYS: begin
                if (sts.keys_ready) begin
                    state_next = ST_ROUND;
                end else begin
                    cmd.key_step = 1'b1;
                end
            end
            ST_ROUND: begin
                if (sts.rounds_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.round = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.need_pad ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                cmd.pad_load = 1'b1;
                state_next   = ST_ROUND;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/aesbm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesbm_dp
// Round datapath, round key store, chaining and mode post-processing.
// ----------------------------------------------------------------------------
module aesbm_dp import aesbm_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dp_cmd_t  cmd,
    input  wire in_word_t s_word,
    input  wire logic [127:0] key,
    input  wire logic [127:0] iv,
    input  wire logic [1:0]   mode,
    output dp_sts_t       sts,
    output out_word_t     res
);

    logic [127:0] rk_mem [NumRounds + 1];
    logic [127:0] rk_cur_reg;
    logic [RkIdxW-1:0] kidx_reg;
    logic         open_reg;
    logic [127:0] chain_reg;
    logic [127:0] st_reg;
    logic [127:0] data_reg;
    logic [RkIdxW-1:0] rnd_reg;
    logic [4:0]   n_reg;
    logic         last_reg;
    logic         dec_reg;
    logic         pad_reg;
    logic [127:0] rk_rd_reg;
    // The pre-whitening key is applied on the first round cycle (rnd 0 marker).
    logic         whiten_reg;
    logic         dec_mode;
    logic         enc_mode;
    logic [127:0] blk;
    logic [127:0] key_next;
    logic [127:0] rnd_out;
    logic [127:0] fin;
    logic [127:0] ctr_mask;
    logic [4:0]   n_eff;
    logic [RkIdxW-1:0] rd_idx;
    logic [RkIdxW-1:0] rd_step;
    logic [7:0]   fill_val;

    assign dec_mode = (mode == MODE_CBC_DEC);
    assign enc_mode = (mode == MODE_CBC_ENC);
    assign blk      = {s_word.block_high, s_word.block_low};
    assign n_eff    = (!s_word.last_block || s_word.byte_count > 5'd16) ? 5'd16
                                                                       : s_word.byte_count;
    assign fill_val = 8'(5'd16 - n_eff);
    assign key_next = next_round_key(rk_cur_reg, RCON[kidx_reg]);

    // Round key index used in the next cycle: encryption walks up, decryption down.
    always_comb begin
        rd_step = whiten_reg ? RkIdxW'(1) : rnd_reg + RkIdxW'(2);
        if (!cmd.round || rd_step > RkIdxW'(NumRounds)) begin
            rd_idx = dec_reg ? RkIdxW'(NumRounds) : '0;
        end else begin
            rd_idx = dec_reg ? RkIdxW'(NumRounds) - rd_step : rd_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_step) begin
            rk_mem[kidx_reg + RkIdxW'(1)] <= key_next;
        end else if (cmd.start && !open_reg) begin
            rk_mem[0] <= key;
        end
        rk_rd_reg <= rk_mem[rd_idx];
    end

    always_comb begin
        if (dec_reg) begin
            rnd_out = inv_shift_sub(st_reg) ^ rk_rd_reg;
            if (rnd_reg != RkIdxW'(NumRounds - 1)) begin
                rnd_out = inv_mix(rnd_out);
            end
        end else begin
            rnd_out = enc_round(st_reg, rnd_reg == RkIdxW'(NumRounds - 1)) ^ rk_rd_reg;
        end
    end

    always_comb begin
        ctr_mask = '0;
        for (int i = 0; i < 16; i++) begin
            ctr_mask[127 - 8*i -: 8] = (5'(i) < n_reg) ? 8'hff : 8'h00;
        end
        case (mode)
            MODE_CBC_ENC: fin = st_reg;
            MODE_CBC_DEC: fin = st_reg ^ chain_reg;
            default:      fin = (st_reg ^ data_reg) & ctr_mask;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            chain_reg  <= '0;
            kidx_reg   <= '0;
            pad_reg    <= 1'b0;
            whiten_reg <= 1'b0;
            rnd_reg    <= '0;
        end else begin
            if (cmd.start) begin
                logic [127:0] cv;
                cv       = open_reg ? chain_reg : iv;
                data_reg <= blk;
                last_reg <= s_word.last_block;
                dec_reg  <= dec_mode;
                n_reg    <= n_eff;
                rnd_reg  <= '0;
                whiten_reg <= 1'b1;
                if (!open_reg) begin
                    rk_cur_reg <= key;
                    kidx_reg   <= '0;
                    chain_reg  <= iv;
                end
                open_reg <= ~s_word.last_block;
                pad_reg  <= enc_mode && s_word.last_block && n_eff == 5'd16;
                if (enc_mode) begin
                    logic [127:0] pb;
                    pb = blk;
                    for (int i = 0; i < 16; i++) begin
                        if (5'(i) >= n_eff) begin
                            pb[127 - 8*i -: 8] = fill_val;
                        end
                    end
                    st_reg <= pb ^ cv;
                end else if (dec_mode) begin
                    st_reg <= blk;
                end else begin
                    st_reg <= cv;
                end
            end
            if (cmd.key_step) begin
                rk_cur_reg <= key_next;
                kidx_reg   <= kidx_reg + RkIdxW'(1);
            end
            if (cmd.pad_load) begin
                st_reg     <= {16{8'h10}} ^ chain_reg;
                pad_reg    <= 1'b0;
                rnd_reg    <= '0;
                whiten_reg <= 1'b1;
            end
            if (cmd.round) begin
                if (whiten_reg) begin
                    st_reg     <= st_reg ^ rk_rd_reg;
                    whiten_reg <= 1'b0;
                end else begin
                    st_reg  <= rnd_out;
                    rnd_reg <= rnd_reg + RkIdxW'(1);
                end
            end
            if (cmd.emit) begin
                case (mode)
                    MODE_CBC_ENC: chain_reg <= st_reg;
                    MODE_CBC_DEC: chain_reg <= data_reg;
                    default:      chain_reg <= chain_reg + 128'd1;
                endcase
                res.out_high <= fin[127:64];
                res.out_low  <= fin[63:0];
                if (mode == MODE_CBC_DEC) begin
                    res.valid_bytes <= !last_reg ? 5'd16
                        : (fin[7:0] > 8'd16) ? 5'd0 : 5'(8'd16 - fin[7:0]);
                end else if (enc_mode) begin
                    res.valid_bytes <= 5'd16;
                end else begin
                    res.valid_bytes <= n_reg;
                end
                res.last_result <= last_reg && !pad_reg;
            end
        end
    end

    // In the padded flow the pad block continues the chain from the emitted result.
    assign sts.keys_ready  = kidx_reg == RkIdxW'(NumRounds) || open_reg && !cmd.key_step
                             && kidx_reg == RkIdxW'(NumRounds);
    assign sts.rounds_done = rnd_reg == RkIdxW'(NumRounds);
    assign sts.need_pad    = pad_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/aes128_block_mode_engine_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_mode_engine_top
// AES-128 engine for CBC encrypt with padding, CBC decrypt and CTR.
// ----------------------------------------------------------------------------
// Usage:
//   Write key, IV and mode through cfg_we/cfg_idx/cfg_wdata while idle.
//   Feed a message as words on s_valid/s_ready; mark the final word with
//   last_block. Results leave on m_valid/m_ready, one per word, plus an
//   extra pad word when a CBC encrypt message ends on a full block.
// Sequence:
//   One round per cycle. A word takes a load step, a key check, whitening,
//   the ten rounds, a done step and an emit step. The first word of a
//   message adds key expansion; a pad word adds a pad load, whitening,
//   the ten rounds, a done step and an emit step.
//   Words are processed one at a time; the CBC chain sets this.
// Stall:
//   The result register holds while m_ready is low; a finished word waits
//   in the sequencer until the register frees up, then input resumes.
// Reset:
//   Clears configuration and control registers, mode CBC encrypt, no message open, no result pending.
// ----------------------------------------------------------------------------
module aes128_block_mode_engine_top import aesbm_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_word,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_word
);

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [1:0]  mode_reg;
    logic        m_valid_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    out_word_t   res;

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= MODE_CBC_ENC;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                REG_IV_HIGH:  iv_high_reg  <= cfg_wdata;
                REG_IV_LOW:   iv_low_reg   <= cfg_wdata;
                REG_MODE:     mode_reg     <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    aesbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (m_valid_reg && !m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aesbm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .key     ({key_high_reg, key_low_reg}),
        .iv      ({iv_high_reg, iv_low_reg}),
        .mode    (mode_reg),
        .sts     (sts),
        .res     (res)
    );

    // Advance output valid: set on emit, drop on accept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = res;

    // Never emit over an unaccepted word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_ready))
        else $error("emit over pending word");

    // A stalled result holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_word))
        else $error("stalled result changed");

    // Input is taken only when no command is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.round || cmd.key_step || cmd.emit))
        else $error("input ready while busy");

endmodule
`default_nettype wire
